### rtl/core/rpn_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// RPN stack calculator. No dependencies.
package rpn_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_OUT_W = 8;
  localparam int REQ_W       = 3;
  localparam int MAG_W       = 2 * DATA_W;
  localparam int DIVIDEND_W  = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIVIDEND_W + 1);

  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUB  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DIV  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK = 3'd5;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_DIVZ    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_SAT     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ADDSUB,
    S_MUL,
    S_DIV_WAIT,
    S_FIX,
    S_APPLY,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    capture;
    logic    addsub;
    logic    mul;
    logic    div_start;
    logic    div_take;
    logic    fix;
    logic    push;
    logic    pop_write;
    logic    set_status;
    status_t status;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             empty;
    logic             lt2;
    logic             full;
    logic             b_zero;
    logic             sat;
    logic             div_done;
    logic             out_free;
  } stat_t;

endpackage

### rtl/core/rpn_div.sv
// Restoring divider, one quotient bit per cycle, for the RPN datapath.
// Depends on rpn_pkg.
module rpn_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [rpn_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [rpn_pkg::DATA_W-1:0]       divisor,
  output logic                             done,
  output logic [rpn_pkg::DIVIDEND_W-1:0]   quotient
);

  logic [rpn_pkg::DATA_W-1:0]     rem_r;
  logic [rpn_pkg::DIVIDEND_W-1:0] quo_r;
  logic [rpn_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                           busy_r;
  logic                           done_r;
  logic [rpn_pkg::DATA_W:0]       shifted;
  logic [rpn_pkg::DATA_W+1:0]     diff_w;
  logic                           fits;

  assign shifted = {rem_r, quo_r[rpn_pkg::DIVIDEND_W-1]};
  assign diff_w  = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = ~diff_w[rpn_pkg::DATA_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= rpn_pkg::DIV_CNT_W'(rpn_pkg::DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rpn_pkg::DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? diff_w[rpn_pkg::DATA_W-1:0] : shifted[rpn_pkg::DATA_W-1:0];
      quo_r <= {quo_r[rpn_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/rpn_datapath.sv
// Operand stack memory, top-of-stack register, arithmetic and result word.
// Depends on rpn_pkg and rpn_div.
module rpn_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rpn_pkg::cmd_t                      cmd,
  output rpn_pkg::stat_t                     stat,
  input  logic [rpn_pkg::REQ_W-1:0]          in_req_type,
  input  logic signed [rpn_pkg::DATA_W-1:0]  in_operand_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rpn_pkg::DATA_W-1:0]  out_top_value,
  output logic                               out_top_valid,
  output logic [2:0]                         out_status,
  output logic [rpn_pkg::DEPTH_OUT_W-1:0]    out_stack_depth
);

  localparam logic [rpn_pkg::MAG_W-1:0] MAG_NEG_LIM = rpn_pkg::MAG_W'(64'h8000_0000);
  localparam logic [rpn_pkg::MAG_W-1:0] MAG_POS_LIM = rpn_pkg::MAG_W'(64'h7FFF_FFFF);

  logic [rpn_pkg::DATA_W-1:0]      mem [rpn_pkg::STACK_DEPTH];
  logic [rpn_pkg::DATA_W-1:0]      rd_data_r;
  logic [rpn_pkg::DATA_W-1:0]      top_r;
  logic [rpn_pkg::CNT_W-1:0]       count_r;
  logic [rpn_pkg::REQ_W-1:0]       req_r;
  logic [rpn_pkg::DATA_W-1:0]      val_r;
  logic [rpn_pkg::MAG_W-1:0]       mag_r;
  logic                            neg_r;
  logic [rpn_pkg::DATA_W-1:0]      res_r;
  logic                            sat_r;
  rpn_pkg::status_t                status_r;
  logic                            out_valid_r;
  logic [rpn_pkg::DATA_W-1:0]      out_top_value_r;
  logic                            out_top_valid_r;
  rpn_pkg::status_t                out_status_r;
  logic [rpn_pkg::DEPTH_OUT_W-1:0] out_depth_r;

  logic [rpn_pkg::CNT_W-1:0]       cnt_m1;
  logic [rpn_pkg::CNT_W-1:0]       cnt_m2;
  logic                            empty;
  logic                            mem_we;
  logic [rpn_pkg::DATA_W-1:0]      a;
  logic [rpn_pkg::DATA_W-1:0]      b;
  logic [rpn_pkg::DATA_W-1:0]      ma;
  logic [rpn_pkg::DATA_W-1:0]      mb;
  logic [rpn_pkg::MAG_W-1:0]       prod_w;
  logic [rpn_pkg::DATA_W:0]        sum_w;
  logic [rpn_pkg::DATA_W-1:0]      addsub_res;
  logic                            addsub_sat;
  logic [rpn_pkg::MAG_W-1:0]       neg_mag;
  logic [rpn_pkg::DATA_W-1:0]      fix_res;
  logic                            fix_sat;
  logic [rpn_pkg::DIVIDEND_W-1:0]  div_dividend;
  logic [rpn_pkg::DIVIDEND_W-1:0]  div_quo;
  logic                            div_done;

  assign cnt_m1 = count_r - 1'b1;
  assign cnt_m2 = count_r - 2'd2;
  assign empty  = (count_r == '0);
  assign mem_we = cmd.push && !empty;

  assign a  = rd_data_r;
  assign b  = top_r;
  assign ma = a[rpn_pkg::DATA_W-1] ? ('0 - a) : a;
  assign mb = b[rpn_pkg::DATA_W-1] ? ('0 - b) : b;

  assign prod_w = ma * mb;

  always_comb begin
    if (req_r == rpn_pkg::REQ_SUB) begin
      sum_w = {a[rpn_pkg::DATA_W-1], a} - {b[rpn_pkg::DATA_W-1], b};
    end else begin
      sum_w = {a[rpn_pkg::DATA_W-1], a} + {b[rpn_pkg::DATA_W-1], b};
    end
    addsub_sat = sum_w[rpn_pkg::DATA_W] != sum_w[rpn_pkg::DATA_W-1];
    if (!addsub_sat) begin
      addsub_res = sum_w[rpn_pkg::DATA_W-1:0];
    end else if (sum_w[rpn_pkg::DATA_W]) begin
      addsub_res = MAG_NEG_LIM[rpn_pkg::DATA_W-1:0];
    end else begin
      addsub_res = MAG_POS_LIM[rpn_pkg::DATA_W-1:0];
    end
  end

  assign neg_mag = '0 - mag_r;

  always_comb begin
    if (neg_r) begin
      fix_sat = mag_r > MAG_NEG_LIM;
      fix_res = fix_sat ? MAG_NEG_LIM[rpn_pkg::DATA_W-1:0] : neg_mag[rpn_pkg::DATA_W-1:0];
    end else begin
      fix_sat = mag_r > MAG_POS_LIM;
      fix_res = fix_sat ? MAG_POS_LIM[rpn_pkg::DATA_W-1:0] : mag_r[rpn_pkg::DATA_W-1:0];
    end
  end

  assign div_dividend = rpn_pkg::DIVIDEND_W'(ma) << rpn_pkg::FRAC_BITS;

  rpn_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (mb),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[rpn_pkg::IDX_W-1:0]] <= top_r;
    end
    if (cmd.capture) begin
      rd_data_r <= mem[cnt_m2[rpn_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push) begin
      count_r <= count_r + 1'b1;
    end else if (cmd.pop_write) begin
      count_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req_type;
      val_r <= in_operand_value;
    end
    if (cmd.push) begin
      top_r <= val_r;
    end else if (cmd.pop_write) begin
      top_r <= res_r;
    end
    if (cmd.addsub) begin
      res_r <= addsub_res;
      sat_r <= addsub_sat;
    end else if (cmd.fix) begin
      res_r <= fix_res;
      sat_r <= fix_sat;
    end
    if (cmd.mul) begin
      mag_r <= prod_w >> rpn_pkg::FRAC_BITS;
      neg_r <= a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1];
    end else if (cmd.div_start) begin
      neg_r <= a[rpn_pkg::DATA_W-1] ^ b[rpn_pkg::DATA_W-1];
    end else if (cmd.div_take) begin
      mag_r <= rpn_pkg::MAG_W'(div_quo);
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_top_value_r <= empty ? '0 : top_r;
      out_top_valid_r <= !empty;
      out_status_r    <= status_r;
      out_depth_r     <= rpn_pkg::DEPTH_OUT_W'(count_r);
    end
  end

  assign stat.req      = req_r;
  assign stat.empty    = empty;
  assign stat.lt2      = count_r < rpn_pkg::CNT_W'(2);
  assign stat.full     = count_r == rpn_pkg::CNT_W'(rpn_pkg::STACK_DEPTH);
  assign stat.b_zero   = top_r == '0;
  assign stat.sat      = sat_r;
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_top_value   = out_top_value_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_status      = out_status_r;
  assign out_stack_depth = out_depth_r;

endmodule

### rtl/core/rpn_ctrl.sv
// Sequencing state machine for the RPN calculator; drives datapath commands.
// Depends on rpn_pkg.
module rpn_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rpn_pkg::stat_t stat,
  output rpn_pkg::cmd_t  cmd
);

  rpn_pkg::ctrl_state_t state_r;
  rpn_pkg::ctrl_state_t state_nxt;
  logic                 is_bin;
  logic                 div_zero;
  logic                 do_arith;

  assign is_bin   = (stat.req == rpn_pkg::REQ_ADD) || (stat.req == rpn_pkg::REQ_SUB) ||
                    (stat.req == rpn_pkg::REQ_MUL) || (stat.req == rpn_pkg::REQ_DIV);
  assign div_zero = (stat.req == rpn_pkg::REQ_DIV) && stat.b_zero;
  assign do_arith = is_bin && !stat.lt2 && !div_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpn_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = rpn_pkg::S_DECODE;
        end
      end
      rpn_pkg::S_DECODE: begin
        if (!do_arith) begin
          state_nxt = rpn_pkg::S_APPLY;
        end else if (stat.req == rpn_pkg::REQ_MUL) begin
          state_nxt = rpn_pkg::S_MUL;
        end else if (stat.req == rpn_pkg::REQ_DIV) begin
          state_nxt = rpn_pkg::S_DIV_WAIT;
        end else begin
          state_nxt = rpn_pkg::S_ADDSUB;
        end
      end
      rpn_pkg::S_ADDSUB:   state_nxt = rpn_pkg::S_APPLY;
      rpn_pkg::S_MUL:      state_nxt = rpn_pkg::S_FIX;
      rpn_pkg::S_DIV_WAIT: begin
        if (stat.div_done) begin
          state_nxt = rpn_pkg::S_FIX;
        end
      end
      rpn_pkg::S_FIX:      state_nxt = rpn_pkg::S_APPLY;
      rpn_pkg::S_APPLY:    state_nxt = rpn_pkg::S_DONE;
      rpn_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_nxt = rpn_pkg::S_IDLE;
        end
      end
      default:             state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      rpn_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      rpn_pkg::S_DECODE: begin
        cmd.div_start = do_arith && (stat.req == rpn_pkg::REQ_DIV);
      end
      rpn_pkg::S_ADDSUB:   cmd.addsub = 1'b1;
      rpn_pkg::S_MUL:      cmd.mul = 1'b1;
      rpn_pkg::S_DIV_WAIT: cmd.div_take = stat.div_done;
      rpn_pkg::S_FIX:      cmd.fix = 1'b1;
      rpn_pkg::S_APPLY: begin
        cmd.set_status = 1'b1;
        case (stat.req)
          rpn_pkg::REQ_PUSH: begin
            if (stat.full) begin
              cmd.status = rpn_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          rpn_pkg::REQ_ADD, rpn_pkg::REQ_SUB, rpn_pkg::REQ_MUL, rpn_pkg::REQ_DIV: begin
            if (stat.lt2) begin
              cmd.status = rpn_pkg::ST_UNDER;
            end else if (div_zero) begin
              cmd.status = rpn_pkg::ST_DIVZ;
            end else begin
              cmd.pop_write = 1'b1;
              cmd.status    = stat.sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
            end
          end
          rpn_pkg::REQ_PEEK: begin
            cmd.status = stat.empty ? rpn_pkg::ST_UNDER : rpn_pkg::ST_OK;
          end
          default: cmd.status = rpn_pkg::ST_UNKNOWN;
        endcase
      end
      rpn_pkg::S_DONE:     cmd.load_out = stat.out_free;
      default:             cmd = '0;
    endcase
  end

endmodule

### rtl/core/rpn_stack_calculator_top.sv
// Top level of the RPN stack calculator: controller plus datapath.
// Depends on rpn_pkg, rpn_ctrl, rpn_datapath (and rpn_div below it).
//
// One request word at a time: push a signed Q16.16 value, add, subtract,
// multiply or divide the two top entries (second from top op top), or peek.
// Every request returns one result word with the new top, its valid flag, a
// status code and the stack depth. Push, peek and any rejected request pass
// through decode, apply and done; add and subtract add an add/subtract step;
// multiply adds one 32x32 multiply stage and one saturate stage; divide
// waits on the bit-serial restoring divider (48 quotient bits, one per cycle).
// A new request is taken in the cycle after the previous result has been
// loaded into the output register, which holds it until the consumer takes it;
// a full output register stalls the load. No reset clearing pass.
module rpn_stack_calculator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rpn_pkg::REQ_W-1:0]           in_req_type,
  input  logic signed [rpn_pkg::DATA_W-1:0]   in_operand_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [rpn_pkg::DATA_W-1:0]   out_top_value,
  output logic                                out_top_valid,
  output logic [2:0]                          out_status,
  output logic [rpn_pkg::DEPTH_OUT_W-1:0]     out_stack_depth
);

  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t stat;

  rpn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rpn_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_req_type),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_top_value    (out_top_value),
    .out_top_valid    (out_top_valid),
    .out_status       (out_status),
    .out_stack_depth  (out_stack_depth)
  );

endmodule
